// ----- design/double_ended_queue_top_macros.svh -----
// ---------------------------------------------------------------------------
// double_ended_queue_top_macros
// assertion macros for the checker file of the deque block
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// clocked assertion, off while reset is high
`define DEQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define DEQ_ASSERT_RESET(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/deq_pkg.sv -----
// ---------------------------------------------------------------------------
// deq_pkg
// shared widths, operation and status codes and cell commands of the deque
// ---------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int OP_BITS      = 3;
   localparam int PAYLOAD_BITS = 32;
   localparam int WORD_OUT_BITS = 32;
   localparam int POS_BITS     = 6;
   localparam int STATUS_BITS  = 2;
   localparam int OCC_BITS     = 7;

   localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR      = 3'd4;
   localparam logic [OP_BITS-1:0] OP_DUMP       = 3'd5;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   // command that every cell of the row follows
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_SHIFT_R,
      CMD_SHIFT_L,
      CMD_ROTATE,
      CMD_WRITE_TAIL
   } cell_cmd_type;

endpackage

// ----- design/deq_cell.sv -----
// ---------------------------------------------------------------------------
// deq_cell
// one storage cell of the deque row, takes a neighbor's, the head or the fill word
// ---------------------------------------------------------------------------
module deq_cell #(
   parameter int WORD_BITS = deq_pkg::WORD_BITS_DEFAULT,
   parameter int DEPTH     = deq_pkg::DEPTH_DEFAULT,
   parameter int INDEX     = 0,
   localparam int CNTW     = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  deq_pkg::cell_cmd_type cmd,
   input  logic [CNTW-1:0]       count,
   input  logic [WORD_BITS-1:0]  left_word,
   input  logic [WORD_BITS-1:0]  right_word,
   input  logic [WORD_BITS-1:0]  head_word,
   input  logic [WORD_BITS-1:0]  fill_word,
   output logic [WORD_BITS-1:0]  word
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic                 is_tail;
   logic                 is_last;

   // first free cell and last occupied cell
   assign is_tail = (count == CNTW'(INDEX));
   assign is_last = (count == CNTW'(INDEX + 1));

   always_comb begin
      word_in = word_ff;
      case (cmd)
         deq_pkg::CMD_SHIFT_R:    word_in = left_word;
         deq_pkg::CMD_SHIFT_L:    word_in = right_word;
         deq_pkg::CMD_ROTATE:     word_in = is_last ? head_word : right_word;
         deq_pkg::CMD_WRITE_TAIL: begin
            if (is_tail) begin
               word_in = fill_word;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ----- design/double_ended_queue_top.sv -----
// ---------------------------------------------------------------------------
// double_ended_queue_top
// bounded double-ended queue built as a row of word cells, front at cell 0
// ---------------------------------------------------------------------------
// req channel: one operation per transfer (op, payload); req_stall is high
//    while an operation is still at work or a stalled result still waits
// rsp channel: word_out, position, status, occupancy, last; every result
//    sits in an output register, so it appears the cycle after it is made
// push front, push back, pop front, clear and unused codes: a new transfer may
//    follow in the next cycle as the result leaves
// pop back: the row rotates left count - 1 times until the rear word sits in
//    cell 0, then a pop front removes it
// dump: one result per cycle after the accepting cycle while not stalled;
//    each result rotates the row by one, so the order is back after the last
// empty or full queue: one result with a status code, state unchanged
// rsp_stall high: the result register holds, the sequencer waits before its next result
// reset: occupancy and sequencer clear at once; cell contents are left as
//    they are and are never read before a push writes them
// ---------------------------------------------------------------------------
module double_ended_queue_top #(
   parameter int DEPTH     = deq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = deq_pkg::WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [deq_pkg::OP_BITS-1:0]       req_op,
   input  logic [deq_pkg::PAYLOAD_BITS-1:0]  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [deq_pkg::WORD_OUT_BITS-1:0] rsp_word_out,
   output logic [deq_pkg::POS_BITS-1:0]      rsp_position,
   output logic [deq_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [deq_pkg::OCC_BITS-1:0]      rsp_occupancy,
   output logic                              rsp_last
);

   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int IDXW = $clog2(DEPTH);

   // sequencer states
   localparam logic [1:0] STATE_IDLE   = 2'd0;
   localparam logic [1:0] STATE_ROTATE = 2'd1;
   localparam logic [1:0] STATE_DUMP   = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   // rotations still to go on pop back, entry index on dump
   logic [IDXW-1:0] step_ff, step_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::WORD_OUT_BITS-1:0] rsp_word_ff;
   logic [deq_pkg::POS_BITS-1:0]      rsp_pos_ff;
   logic [deq_pkg::STATUS_BITS-1:0]   rsp_status_ff;
   logic [deq_pkg::OCC_BITS-1:0]      rsp_occ_ff;
   logic                              rsp_last_ff;

   // result being made this cycle
   logic                              emit;
   logic [deq_pkg::WORD_OUT_BITS-1:0] e_word;
   logic [deq_pkg::POS_BITS-1:0]      e_pos;
   logic [deq_pkg::STATUS_BITS-1:0]   e_status;
   logic                              e_last;

   logic out_free;
   logic req_accept;
   logic count_full;
   logic count_zero;

   deq_pkg::cell_cmd_type cmd;

   logic [WORD_BITS-1:0] cell_word [DEPTH];
   logic [WORD_BITS-1:0] fill_word;
   logic [63:0]          payload_wide;
   logic [63:0]          head_wide;
   logic [deq_pkg::WORD_OUT_BITS-1:0] head_out;

   // payload masked to the word width on the way in, zero-extended out
   assign payload_wide = 64'(req_payload);
   assign fill_word    = payload_wide[WORD_BITS-1:0];
   assign head_wide    = 64'(cell_word[0]);
   assign head_out     = head_wide[deq_pkg::WORD_OUT_BITS-1:0];

   // row of cells; cell 0 takes the fresh word on a front push
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_w;
      logic [WORD_BITS-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = fill_word;
      end else begin : g_inner_l
         assign left_w = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_w = cell_word[i];
      end else begin : g_inner_r
         assign right_w = cell_word[i+1];
      end

      deq_cell #(
         .WORD_BITS (WORD_BITS),
         .DEPTH     (DEPTH),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .left_word  (left_w),
         .right_word (right_w),
         .head_word  (cell_word[0]),
         .fill_word  (fill_word),
         .word       (cell_word[i])
      );
   end

   // result register is free when empty or drained this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == STATE_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign count_full = (count_ff == CNTW'(DEPTH));
   assign count_zero = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      cmd          = deq_pkg::CMD_HOLD;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      emit         = 1'b0;
      e_word       = '0;
      e_pos        = '0;
      e_status     = deq_pkg::STATUS_DONE;
      e_last       = 1'b1;

      unique case (state_ff)
         STATE_IDLE: begin
            if (req_accept) begin
               emit = 1'b1;
               unique case (req_op) inside
                  deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                     if (count_full) begin
                        e_status = deq_pkg::STATUS_FULL;
                     end else begin
                        cmd      = (req_op == deq_pkg::OP_PUSH_FRONT) ?
                                   deq_pkg::CMD_SHIFT_R : deq_pkg::CMD_WRITE_TAIL;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  deq_pkg::OP_POP_FRONT: begin
                     if (count_zero) begin
                        e_status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd      = deq_pkg::CMD_SHIFT_L;
                        e_word   = head_out;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  deq_pkg::OP_POP_BACK: begin
                     if (count_zero) begin
                        e_status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        // bring the rear word round to cell 0 first
                        emit     = 1'b0;
                        state_in = STATE_ROTATE;
                        step_in  = IDXW'(count_ff - 1'b1);
                     end
                  end
                  deq_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  deq_pkg::OP_DUMP: begin
                     if (count_zero) begin
                        e_status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        emit     = 1'b0;
                        state_in = STATE_DUMP;
                        step_in  = '0;
                     end
                  end
                  default: begin
                     // unused codes: plain done result
                  end
               endcase
            end
         end
         STATE_ROTATE: begin
            if (step_ff != '0) begin
               cmd     = deq_pkg::CMD_ROTATE;
               step_in = step_ff - 1'b1;
            end else if (out_free) begin
               // rear word now leads, remaining order is the original one
               emit     = 1'b1;
               cmd      = deq_pkg::CMD_SHIFT_L;
               e_word   = head_out;
               count_in = count_ff - 1'b1;
               state_in = STATE_IDLE;
            end
         end
         STATE_DUMP: begin
            if (out_free) begin
               emit    = 1'b1;
               cmd     = deq_pkg::CMD_ROTATE;
               e_word  = head_out;
               e_pos   = deq_pkg::POS_BITS'(step_ff);
               e_last  = ((CNTW'(step_ff) + CNTW'(1)) == count_ff);
               step_in = step_ff + 1'b1;
               if (e_last) begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff   <= e_word;
         rsp_pos_ff    <= e_pos;
         rsp_status_ff <= e_status;
         rsp_occ_ff    <= deq_pkg::OCC_BITS'(count_in);
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word_out  = rsp_word_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- design/deq_checker.sv -----
// ---------------------------------------------------------------------------
// deq_checker
// port-level assertions on the deque results, bound to the top level
// ---------------------------------------------------------------------------
`include "double_ended_queue_top_macros.svh"

module deq_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [deq_pkg::WORD_OUT_BITS-1:0] rsp_word_out,
   input logic [deq_pkg::STATUS_BITS-1:0]   rsp_status,
   input logic [deq_pkg::OCC_BITS-1:0]      rsp_occupancy,
   input logic                              rsp_last
);

   localparam logic [deq_pkg::OCC_BITS-1:0] OCC_DEPTH = DEPTH[deq_pkg::OCC_BITS-1:0];

   // stalled result holds
   `DEQ_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_out) && $stable(rsp_last), "stalled result changed")

   // full status only when every cell is taken
   `DEQ_ASSERT(a_full_occ, rsp_valid && rsp_status == deq_pkg::STATUS_FULL |-> rsp_occupancy == OCC_DEPTH, "full status with free cells")

   // empty status is a single zero result
   `DEQ_ASSERT(a_empty_result, rsp_valid && rsp_status == deq_pkg::STATUS_EMPTY |-> rsp_last && rsp_word_out == '0 && rsp_occupancy == '0, "bad empty result")

   // only a dump gives non-final results, and it holds off new transfers
   `DEQ_ASSERT(a_mid_dump, rsp_valid && !rsp_last |-> rsp_status == deq_pkg::STATUS_DONE && req_stall, "bad non-final result")

   // no result right after reset
   `DEQ_ASSERT_RESET(a_reset_idle, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind double_ended_queue_top deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
